[hdl/ncor_pkg.sv]
// Shared types and constants of the normalized autocorrelation core.
package ncor_pkg;

  localparam int ACC_W     = 48;
  localparam int CNT_W     = 6;
  localparam int POS_W     = 16;
  localparam int LEN_W     = 17;
  localparam int LIDX_W    = 5;
  localparam int NORM_W    = 16;
  localparam int FRAC_BITS = 15;
  localparam int QUO_W     = 18;
  localparam int REM_W     = ACC_W + QUO_W - 1;
  localparam int DCNT_W    = 5;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LAG_COUNT    = 1'b1;

  localparam logic [POS_W-1:0] BLOCK_LENGTH_RST = 16'd4096;
  localparam logic [CNT_W-1:0] LAG_COUNT_RST    = 6'd8;

  localparam logic [QUO_W-1:0] QUO_POS_MAX = 18'd32767;
  localparam logic [QUO_W-1:0] QUO_NEG_MAX = 18'd32768;
  localparam logic signed [NORM_W-1:0] NORM_POS_SAT = 16'sh7FFF;
  localparam logic signed [NORM_W-1:0] NORM_NEG_SAT = 16'sh8000;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_LOAD,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic             take;
    logic             first;
    logic             acc_v;
    logic             shift;
    logic             short_blk;
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] lim;
    logic [CNT_W-1:0] lags;
  } cell_ctl_t;

endpackage

[hdl/normalized_autocorrelation_core.sv]
// Normalized autocorrelation core: a chain of lag cells with a shared block-end divider.
// Samples stream in at one per cycle; each of the MAX_LAGS cells holds one delay tap and
// one 48-bit lag accumulator, and registers its product and adds it in the next cycle.
// After the final sample of a block the input stalls while the accumulators are shifted
// down the chain into a shared one-bit-per-cycle divider: a flush state completes the last
// accumulation, then each lag is loaded and divided in turn; the stall lasts longer
// while a result waits at the output.
// Results leave through an output register, so the last result may wait while the
// next block streams in.
module normalized_autocorrelation_core #(
  parameter int MAX_LAGS    = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [ncor_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ncor_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [SAMPLE_BITS-1:0]         in_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ncor_pkg::LIDX_W-1:0]           out_lag_index,
  output logic signed [ncor_pkg::NORM_W-1:0]    out_norm_value,
  output logic                                  out_zero_energy,
  output logic                                  out_last_of_block
);

  ncor_pkg::state_t                  state_r;
  ncor_pkg::state_t                  state_nxt;
  logic [ncor_pkg::POS_W-1:0]        blen_r;
  logic [ncor_pkg::CNT_W-1:0]        lagc_r;
  logic [ncor_pkg::POS_W-1:0]        pos_r;
  logic                              v_r;
  logic [ncor_pkg::CNT_W-1:0]        lag_cnt_r;
  logic signed [ncor_pkg::ACC_W-1:0] den_r;
  logic                              zero_r;
  logic                              out_valid_r;
  logic [ncor_pkg::LIDX_W-1:0]       out_lag_r;
  logic signed [ncor_pkg::NORM_W-1:0] out_norm_r;
  logic                              out_zero_r;
  logic                              out_last_r;

  logic [ncor_pkg::CNT_W-1:0]        lags;
  logic [ncor_pkg::LEN_W-1:0]        len;
  logic                              take;
  logic                              last_sample;
  logic                              last_lag;
  logic                              div_start;
  logic                              shift;
  logic                              out_load;
  logic                              div_done;
  logic signed [ncor_pkg::NORM_W-1:0] div_quot;
  logic signed [ncor_pkg::ACC_W-1:0] div_den;
  ncor_pkg::cell_ctl_t               ctl;

  logic signed [SAMPLE_BITS-1:0]     hist [MAX_LAGS];
  logic signed [ncor_pkg::ACC_W-1:0] accs [MAX_LAGS+1];

  always_comb begin
    if (lagc_r == '0) begin
      lags = ncor_pkg::CNT_W'(1);
    end else if (lagc_r > ncor_pkg::CNT_W'(MAX_LAGS)) begin
      lags = ncor_pkg::CNT_W'(MAX_LAGS);
    end else begin
      lags = lagc_r;
    end
  end

  assign len         = (blen_r == '0) ? {1'b1, {ncor_pkg::POS_W{1'b0}}} : {1'b0, blen_r};
  assign take        = in_valid && in_ready;
  assign last_sample = ({1'b0, pos_r} + 1'b1) >= len;
  assign last_lag    = lag_cnt_r == (lags - 1'b1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ncor_pkg::ST_RUN: begin
        if (take && last_sample) begin
          state_nxt = ncor_pkg::ST_FLUSH;
        end
      end
      ncor_pkg::ST_FLUSH: begin
        state_nxt = ncor_pkg::ST_LOAD;
      end
      ncor_pkg::ST_LOAD: begin
        state_nxt = ncor_pkg::ST_DIV;
      end
      ncor_pkg::ST_DIV: begin
        if (out_load) begin
          state_nxt = last_lag ? ncor_pkg::ST_RUN : ncor_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = ncor_pkg::ST_RUN;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    shift     = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ncor_pkg::ST_RUN: begin
        in_ready = 1'b1;
      end
      ncor_pkg::ST_FLUSH: begin
      end
      ncor_pkg::ST_LOAD: begin
        div_start = 1'b1;
        shift     = 1'b1;
      end
      ncor_pkg::ST_DIV: begin
        out_load = div_done && (!out_valid_r || out_ready);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ncor_pkg::ST_RUN;
      blen_r  <= ncor_pkg::BLOCK_LENGTH_RST;
      lagc_r  <= ncor_pkg::LAG_COUNT_RST;
      pos_r   <= '0;
      v_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v_r     <= take;
      if (take) begin
        pos_r <= last_sample ? '0 : pos_r + 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          ncor_pkg::REG_BLOCK_LENGTH: blen_r <= cfg_wdata[ncor_pkg::POS_W-1:0];
          ncor_pkg::REG_LAG_COUNT:    lagc_r <= cfg_wdata[ncor_pkg::CNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ncor_pkg::ST_FLUSH) begin
      lag_cnt_r <= '0;
    end else if (out_load) begin
      lag_cnt_r <= lag_cnt_r + 1'b1;
    end
    if (state_r == ncor_pkg::ST_LOAD && lag_cnt_r == '0) begin
      den_r  <= accs[0];
      zero_r <= accs[0] == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_lag_r  <= ncor_pkg::LIDX_W'(lag_cnt_r);
      out_norm_r <= zero_r ? '0 : div_quot;
      out_zero_r <= zero_r;
      out_last_r <= last_lag;
    end
  end

  always_comb begin
    ctl.take      = take;
    ctl.first     = pos_r == '0;
    ctl.acc_v     = v_r;
    ctl.shift     = shift;
    ctl.short_blk = len <= ncor_pkg::LEN_W'(lags);
    ctl.pos       = pos_r;
    ctl.lim       = len - ncor_pkg::LEN_W'(lags);
    ctl.lags      = lags;
  end

  assign accs[MAX_LAGS] = '0;

  for (genvar gi = 0; gi < MAX_LAGS; gi++) begin : g_cell
    ncor_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .CELL_IDX   (gi)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .s_in    (in_sample),
      .early_in((gi == 0) ? in_sample : hist[(gi == 0) ? 0 : gi - 1]),
      .hist_out(hist[gi]),
      .acc_in  (accs[gi + 1]),
      .acc_out (accs[gi])
    );
  end

  assign div_den = (lag_cnt_r == '0) ? accs[0] : den_r;

  ncor_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (accs[0]),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  assign out_valid         = out_valid_r;
  assign out_lag_index     = out_lag_r;
  assign out_norm_value    = out_norm_r;
  assign out_zero_energy   = out_zero_r;
  assign out_last_of_block = out_last_r;

`ifndef SYNTHESIS
  a_last_sample_flush: assert property (@(posedge clk) disable iff (!rst_n)
    take && last_sample |=> state_r == ncor_pkg::ST_FLUSH)
    else $error("Final sample of a block did not start the flush.");

  a_flush_accumulates: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ncor_pkg::ST_FLUSH |-> v_r)
    else $error("Flush without a pending accumulation.");

  a_div_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> !div_done)
    else $error("Divider reported done right after a start.");

  a_lag_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> lag_cnt_r < lags)
    else $error("Result loaded for a lag beyond the active lag count.");

  a_block_end_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && last_lag |=> state_r == ncor_pkg::ST_RUN && out_last_of_block)
    else $error("Final lag did not return the core to streaming.");
`endif

endmodule

[hdl/ncor_cell.sv]
// One lag cell: a delay tap, a product register and the lag accumulator.
module ncor_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int CELL_IDX    = 0
) (
  input  logic                                  clk,
  input  ncor_pkg::cell_ctl_t                   ctl,
  input  logic signed [SAMPLE_BITS-1:0]         s_in,
  input  logic signed [SAMPLE_BITS-1:0]         early_in,
  output logic signed [SAMPLE_BITS-1:0]         hist_out,
  input  logic signed [ncor_pkg::ACC_W-1:0]     acc_in,
  output logic signed [ncor_pkg::ACC_W-1:0]     acc_out
);

  logic signed [SAMPLE_BITS-1:0]     hist_r;
  logic signed [2*SAMPLE_BITS-1:0]   prod_r;
  logic                              en_r;
  logic                              first_r;
  logic signed [ncor_pkg::ACC_W-1:0] acc_r;
  logic [ncor_pkg::LEN_W-1:0]        pos_ext;
  logic [ncor_pkg::LEN_W-1:0]        early_pos;
  logic                              en_nxt;

  assign pos_ext   = {1'b0, ctl.pos};
  assign early_pos = pos_ext - ncor_pkg::LEN_W'(CELL_IDX);

  always_comb begin
    en_nxt = (ncor_pkg::CNT_W'(CELL_IDX) < ctl.lags) &&
             (pos_ext >= ncor_pkg::LEN_W'(CELL_IDX)) &&
             !ctl.short_blk && (early_pos < ctl.lim);
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      prod_r  <= early_in * s_in;
      en_r    <= en_nxt;
      first_r <= ctl.first;
      hist_r  <= early_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      acc_r <= acc_in;
    end else if (ctl.acc_v) begin
      acc_r <= (first_r ? '0 : acc_r) + (en_r ? ncor_pkg::ACC_W'(prod_r) : '0);
    end
  end

  assign hist_out = hist_r;
  assign acc_out  = acc_r;

endmodule

[hdl/ncor_div.sv]
// Restoring divider that forms a rounded, saturated Q1.15 ratio of two accumulators.
module ncor_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [ncor_pkg::ACC_W-1:0]   num,
  input  logic signed [ncor_pkg::ACC_W-1:0]   den,
  output logic                                done,
  output logic signed [ncor_pkg::NORM_W-1:0]  quot
);

  logic                          busy_r;
  logic                          prep_r;
  logic                          done_r;
  logic                          neg_r;
  logic [ncor_pkg::ACC_W-1:0]    un_r;
  logic [ncor_pkg::ACC_W-1:0]    ud_r;
  logic [ncor_pkg::REM_W-1:0]    rem_r;
  logic [ncor_pkg::REM_W-1:0]    dsh_r;
  logic [ncor_pkg::QUO_W-1:0]    q_r;
  logic [ncor_pkg::DCNT_W-1:0]   cnt_r;
  logic                          ge;

  assign ge = rem_r >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      prep_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      prep_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      prep_r <= 1'b0;
      if (!prep_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      un_r  <= num[ncor_pkg::ACC_W-1] ? (~num + 1'b1) : num;
      ud_r  <= den[ncor_pkg::ACC_W-1] ? (~den + 1'b1) : den;
      neg_r <= num[ncor_pkg::ACC_W-1] ^ den[ncor_pkg::ACC_W-1];
    end else if (busy_r && prep_r) begin
      rem_r <= ncor_pkg::REM_W'({un_r, {ncor_pkg::FRAC_BITS{1'b0}}}) +
               ncor_pkg::REM_W'(ud_r >> 1);
      dsh_r <= {ud_r, {(ncor_pkg::QUO_W-1){1'b0}}};
      q_r   <= '0;
      cnt_r <= ncor_pkg::DCNT_W'(ncor_pkg::QUO_W - 1);
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[ncor_pkg::QUO_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_comb begin
    if (neg_r) begin
      quot = (q_r > ncor_pkg::QUO_NEG_MAX) ? ncor_pkg::NORM_NEG_SAT
                                           : ncor_pkg::NORM_W'(~q_r + 1'b1);
    end else begin
      quot = (q_r > ncor_pkg::QUO_POS_MAX) ? ncor_pkg::NORM_POS_SAT
                                           : ncor_pkg::NORM_W'(q_r);
    end
  end

  assign done = done_r;

endmodule
